@@ rtl/core/deqs_pkg.sv @@
// shared types and codes for the double-ended queue with search
package deqs_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_POP_FRONT  = 3'd1,
		MODE_PUSH_REAR  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_SEARCH     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD    = 2'd0,
		CMD_SHR     = 2'd1,
		CMD_SHL     = 2'd2,
		CMD_WR_REAR = 2'd3
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_ROT  = 1'b1
	} state_t;

	typedef struct packed {
		cell_cmd_t   cmd;
		logic [31:0] wdata;
	} cell_ctl_t;

	localparam int unsigned DataW = 32;
	localparam int unsigned PosW  = 5;

endpackage

@@ rtl/core/deqs_cell.sv @@
// one storage cell of the queue chain
module deqs_cell #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned INDEX = 0
) (
	input  logic                              clk,
	input  deqs_pkg::cell_ctl_t               ctl,
	input  logic [$clog2(DEPTH+1)-1:0]        count,
	input  logic [deqs_pkg::DataW-1:0]        left_data,
	input  logic [deqs_pkg::DataW-1:0]        right_data,
	output logic [deqs_pkg::DataW-1:0]        data
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [deqs_pkg::DataW-1:0] data_q;
	logic [deqs_pkg::DataW-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.cmd)
			deqs_pkg::CMD_HOLD:    data_d = data_q;
			deqs_pkg::CMD_SHR:     data_d = left_data;
			deqs_pkg::CMD_SHL:     data_d = right_data;
			deqs_pkg::CMD_WR_REAR: begin
				// only the first free cell takes the rear request
				if (count == CW'(INDEX))
					data_d = ctl.wdata;
			end
			default:               data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

@@ rtl/core/deqs_ctrl.sv @@
// sequencer: decodes requests, steers the cell chain and forms results
module deqs_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [2:0]                         mode,
	input  logic [deqs_pkg::DataW-1:0]         value,
	input  logic [deqs_pkg::DataW-1:0]         head_data,
	output deqs_pkg::cell_ctl_t                ctl,
	output logic [$clog2(DEPTH+1)-1:0]         count,
	output logic                               busy,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [deqs_pkg::DataW-1:0]         popped_value,
	output logic [deqs_pkg::PosW-1:0]          position
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KW = $clog2(DEPTH);

	deqs_pkg::state_t state_q, state_d;

	logic [CW-1:0]                count_q, count_d;
	logic [KW-1:0]                k_q, k_d;
	logic                         search_q, search_d;
	logic [deqs_pkg::DataW-1:0]   val_q, val_d;
	logic                         found_q, found_d;
	logic [deqs_pkg::PosW-1:0]    fpos_q, fpos_d;
	logic [deqs_pkg::DataW-1:0]   cap_q, cap_d;

	logic                         done_q, done_d;
	logic [1:0]                   status_q, status_d;
	logic [deqs_pkg::DataW-1:0]   popped_q, popped_d;
	logic [deqs_pkg::PosW-1:0]    position_q, position_d;

	logic                         full, empty, last, hit;
	logic [31:0]                  pos_wide;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign last     = (k_q == KW'(DEPTH - 1));
	assign pos_wide = 32'(k_q) + 32'd1;
	// cell 0 holds entry k during step k of the rotation
	assign hit      = (CW'(k_q) < count_q) && (head_data == val_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			deqs_pkg::ST_IDLE: begin
				if (start && !empty &&
				    (mode == deqs_pkg::MODE_POP_REAR || mode == deqs_pkg::MODE_SEARCH))
					state_d = deqs_pkg::ST_ROT;
			end
			deqs_pkg::ST_ROT: begin
				if (last)
					state_d = deqs_pkg::ST_IDLE;
			end
			default: state_d = deqs_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		ctl.cmd    = deqs_pkg::CMD_HOLD;
		ctl.wdata  = value;
		count_d    = count_q;
		k_d        = k_q;
		search_d   = search_q;
		val_d      = val_q;
		found_d    = found_q;
		fpos_d     = fpos_q;
		cap_d      = cap_q;
		done_d     = 1'b0;
		status_d   = status_q;
		popped_d   = popped_q;
		position_d = position_q;
		case (state_q)
			deqs_pkg::ST_IDLE: begin
				if (start) begin
					done_d     = 1'b1;
					status_d   = deqs_pkg::STAT_OK;
					popped_d   = '0;
					position_d = '0;
					k_d        = '0;
					found_d    = 1'b0;
					fpos_d     = '0;
					cap_d      = '0;
					val_d      = value;
					search_d   = (mode == deqs_pkg::MODE_SEARCH);
					case (mode)
						deqs_pkg::MODE_PUSH_FRONT: begin
							if (full) status_d = deqs_pkg::STAT_FULL;
							else begin
								ctl.cmd = deqs_pkg::CMD_SHR;
								count_d = count_q + CW'(1);
							end
						end
						deqs_pkg::MODE_POP_FRONT: begin
							if (empty) status_d = deqs_pkg::STAT_EMPTY;
							else begin
								ctl.cmd  = deqs_pkg::CMD_SHL;
								popped_d = head_data;
								count_d  = count_q - CW'(1);
							end
						end
						deqs_pkg::MODE_PUSH_REAR: begin
							if (full) status_d = deqs_pkg::STAT_FULL;
							else begin
								ctl.cmd = deqs_pkg::CMD_WR_REAR;
								count_d = count_q + CW'(1);
							end
						end
						deqs_pkg::MODE_POP_REAR,
						deqs_pkg::MODE_SEARCH: begin
							if (empty) status_d = deqs_pkg::STAT_EMPTY;
							else done_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			deqs_pkg::ST_ROT: begin
				// full left rotation; the chain is back in order after DEPTH steps
				ctl.cmd = deqs_pkg::CMD_SHL;
				k_d     = k_q + KW'(1);
				if (search_q) begin
					if (!found_q && hit) begin
						found_d = 1'b1;
						fpos_d  = pos_wide[deqs_pkg::PosW-1:0];
					end
				end else if (CW'(k_q) + CW'(1) == count_q) begin
					cap_d = head_data;
				end
				if (last) begin
					done_d = 1'b1;
					if (search_q) begin
						if (found_q) begin
							status_d   = deqs_pkg::STAT_OK;
							position_d = fpos_q;
						end else if (hit) begin
							status_d   = deqs_pkg::STAT_OK;
							position_d = pos_wide[deqs_pkg::PosW-1:0];
						end else begin
							status_d   = deqs_pkg::STAT_NOT_FOUND;
							position_d = '0;
						end
						popped_d = '0;
					end else begin
						status_d   = deqs_pkg::STAT_OK;
						position_d = '0;
						popped_d   = (CW'(k_q) + CW'(1) == count_q) ? head_data : cap_q;
						count_d    = count_q - CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deqs_pkg::ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		search_q   <= search_d;
		val_q      <= val_d;
		found_q    <= found_d;
		fpos_q     <= fpos_d;
		cap_q      <= cap_d;
		status_q   <= status_d;
		popped_q   <= popped_d;
		position_q <= position_d;
	end

	assign count        = count_q;
	assign busy         = (state_q == deqs_pkg::ST_ROT);
	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign position     = position_q;

endmodule

@@ rtl/core/double_ended_queue_with_search.sv @@
// top level: bounded deque of signed words held in a chain of cells, with linear search
//
// channel  | ports                              | marker
// ---------+------------------------------------+------------------
// request  | mode, value                        | start & !busy
// result   | status, popped_value, position     | done (one cycle)
//
// pushes, pop front, unused codes and any request on an empty queue need no rotation;
// the result shows the next cycle.
// pop rear and search on a non-empty queue rotate the whole chain once past cell 0:
// busy for the whole rotation, result on the cycle after the last step.
// arst_n clears the count and the sequencer; cell contents are not reset.
// done is a one-cycle strobe, the receiver cannot stall it.
module double_ended_queue_with_search #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic [4:0]         position
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	deqs_pkg::cell_ctl_t        ctl;
	logic [CW-1:0]              count;
	logic [deqs_pkg::DataW-1:0] cell_data [DEPTH];
	logic [deqs_pkg::DataW-1:0] pop_data;
	logic                       req;

	assign req = start && !busy;

	deqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (req),
		.mode         (mode),
		.value        (value),
		.head_data    (cell_data[0]),
		.ctl          (ctl),
		.count        (count),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.popped_value (pop_data),
		.position     (position)
	);

	assign popped_value = pop_data;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// the last cell wraps to cell 0 so a left shift doubles as rotation
		deqs_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count),
			.left_data  ((i == 0) ? ctl.wdata : cell_data[(i + DEPTH - 1) % DEPTH]),
			.right_data (cell_data[(i + 1) % DEPTH]),
			.data       (cell_data[i])
		);
	end

endmodule

@@ sim/deqs_checker.sv @@
// request and result monitor for the deque: predicts every result and compares it field by field
module deqs_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [2:0]                        mode,
	input  logic signed [deqs_pkg::DataW-1:0] value,
	input  logic                              done,
	input  logic [1:0]                        status,
	input  logic signed [deqs_pkg::DataW-1:0] popped_value,
	input  logic [deqs_pkg::PosW-1:0]         position,
	output int unsigned                       fail_count,
	output int unsigned                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		deqs_pkg::status_t                 st;
		logic signed [deqs_pkg::DataW-1:0] popped;
		logic [deqs_pkg::PosW-1:0]         pos;
	} outcome_t;

	logic signed [deqs_pkg::DataW-1:0] slots [DEPTH];
	int unsigned head;
	int unsigned fill;
	int unsigned mismatches;
	outcome_t pending_q [$];
	outcome_t oldest;

	assign fail_count = mismatches;

	// applies one request to the shadow ring and returns the result it should give
	function automatic outcome_t apply_request(input logic [2:0] op,
		input logic signed [deqs_pkg::DataW-1:0] v);
		outcome_t o;
		o.st = deqs_pkg::STAT_OK;
		o.popped = '0;
		o.pos = '0;
		case (op)
			deqs_pkg::MODE_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					o.st = deqs_pkg::STAT_FULL;
				end else begin
					head = (head + DEPTH - 1) % DEPTH;
					slots[head] = v;
					fill++;
				end
			end
			deqs_pkg::MODE_POP_FRONT: begin
				if (fill == 0) begin
					o.st = deqs_pkg::STAT_EMPTY;
				end else begin
					o.popped = slots[head];
					head = (head + 1) % DEPTH;
					fill--;
				end
			end
			deqs_pkg::MODE_PUSH_REAR: begin
				if (fill >= DEPTH) begin
					o.st = deqs_pkg::STAT_FULL;
				end else begin
					slots[(head + fill) % DEPTH] = v;
					fill++;
				end
			end
			deqs_pkg::MODE_POP_REAR: begin
				if (fill == 0) begin
					o.st = deqs_pkg::STAT_EMPTY;
				end else begin
					o.popped = slots[(head + fill - 1) % DEPTH];
					fill--;
				end
			end
			deqs_pkg::MODE_SEARCH: begin
				if (fill == 0) begin
					o.st = deqs_pkg::STAT_EMPTY;
				end else begin
					o.st = deqs_pkg::STAT_NOT_FOUND;
					for (int i = 0; i < fill; i++) begin
						if (slots[(head + i) % DEPTH] == v) begin
							o.st = deqs_pkg::STAT_OK;
							o.pos = deqs_pkg::PosW'(i + 1);
							break;
						end
					end
				end
			end
			default: begin
				// unused codes leave everything alone
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			mismatches = 0;
			pending_q.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_q.size() == 0) begin
					$display("%0t: result with no request pending: status %0d popped %0d position %0d",
						$time, status, popped_value, position);
					mismatches++;
				end else begin
					oldest = pending_q.pop_front();
					if (status !== oldest.st) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, oldest.st, status);
						mismatches++;
					end
					if (popped_value !== oldest.popped) begin
						$display("%0t: popped_value mismatch, expected %0d, actual %0d",
							$time, oldest.popped, popped_value);
						mismatches++;
					end
					if (position !== oldest.pos) begin
						$display("%0t: position mismatch, expected %0d, actual %0d",
							$time, oldest.pos, position);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				pending_q.push_back(apply_request(mode, value));
			outstanding <= pending_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// stimulus and verdict for the deque with search
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH = 16;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
	localparam logic signed [deqs_pkg::DataW-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [deqs_pkg::DataW-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [deqs_pkg::DataW-1:0] VAL_FILL = 32'sd1000;
	localparam int unsigned BIAS_FILL = 0;
	localparam int unsigned BIAS_DRAIN = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] mode = '0;
	logic signed [deqs_pkg::DataW-1:0] value = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [deqs_pkg::DataW-1:0] popped_value;
	logic [deqs_pkg::PosW-1:0] position;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned idle_pct;
	logic signed [deqs_pkg::DataW-1:0] pushed_vals [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	double_ended_queue_with_search #(.DEPTH(QDEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode), .value(value),
		.busy(busy), .done(done), .status(status), .popped_value(popped_value),
		.position(position)
	);

	deqs_checker #(.DEPTH(QDEPTH)) queue_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.value(value), .done(done), .status(status), .popped_value(popped_value),
		.position(position), .fail_count(fail_count), .outstanding(outstanding)
	);

	// optional idle stretch with junk on the bus, then hold the request until taken
	task automatic send_request(input logic [2:0] m,
		input logic signed [deqs_pkg::DataW-1:0] v);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do begin
				mode <= 3'($urandom);
				value <= $urandom;
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		mode <= m;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// runs of requests leaning toward filling, draining or neither
	task automatic run_phase(input int unsigned n);
		int unsigned bias;
		int unsigned push_pct;
		int unsigned r;
		logic [2:0] m;
		logic signed [deqs_pkg::DataW-1:0] v;
		bias = BIAS_FILL;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 24 == 0)
				bias = $urandom_range(2);
			push_pct = (bias == BIAS_FILL) ? 65 : (bias == BIAS_DRAIN) ? 15 : 40;
			r = $urandom_range(99);
			case ($urandom_range(9))
				0, 1, 2, 3: v = $urandom_range(15);
				4: v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
				default: v = $urandom;
			endcase
			if (r < 3) begin
				m = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
			end else if (r < 23) begin
				m = deqs_pkg::MODE_SEARCH;
				if (pushed_vals.size() != 0 && $urandom_range(99) < 60)
					v = pushed_vals[$urandom_range(pushed_vals.size() - 1)];
			end else if ($urandom_range(99) < push_pct) begin
				m = $urandom_range(1) ? deqs_pkg::MODE_PUSH_REAR : deqs_pkg::MODE_PUSH_FRONT;
				pushed_vals.push_back(v);
				if (pushed_vals.size() > 32)
					void'(pushed_vals.pop_front());
			end else begin
				m = $urandom_range(1) ? deqs_pkg::MODE_POP_REAR : deqs_pkg::MODE_POP_FRONT;
			end
			send_request(m, v);
		end
	endtask

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	initial begin
		idle_pct = 26;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops and search on an empty queue
		send_request(deqs_pkg::MODE_POP_FRONT, VAL_MAX);
		send_request(deqs_pkg::MODE_POP_REAR, VAL_MIN);
		send_request(deqs_pkg::MODE_SEARCH, '0);
		// extremes at both ends, then look them up, search a missing value and send the unused codes
		send_request(deqs_pkg::MODE_PUSH_REAR, VAL_MAX);
		send_request(deqs_pkg::MODE_PUSH_FRONT, VAL_MIN);
		send_request(deqs_pkg::MODE_SEARCH, VAL_MIN);
		send_request(deqs_pkg::MODE_SEARCH, VAL_MAX);
		send_request(deqs_pkg::MODE_SEARCH, '0);
		send_request(MODE_UNUSED_LO, VAL_MAX);
		send_request(MODE_UNUSED_HI, VAL_MIN);
		// fill up, the last rear push lands at position 16
		for (int k = 0; k < QDEPTH - 2; k++)
			send_request(k[0] ? deqs_pkg::MODE_PUSH_REAR : deqs_pkg::MODE_PUSH_FRONT,
				VAL_FILL + k);
		send_request(deqs_pkg::MODE_PUSH_FRONT, VAL_MAX);
		send_request(deqs_pkg::MODE_PUSH_REAR, VAL_MIN);
		send_request(deqs_pkg::MODE_SEARCH, VAL_FILL + QDEPTH - 3);
		send_request(deqs_pkg::MODE_POP_REAR, '0);
		send_request(deqs_pkg::MODE_POP_FRONT, '0);

		run_phase(310);
		idle_pct = 53;
		run_phase(310);
		idle_pct = 0;
		run_phase(300);

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (QDEPTH + 4) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/deqs_pkg.sv
rtl/core/deqs_cell.sv
rtl/core/deqs_ctrl.sv
rtl/core/double_ended_queue_with_search.sv
sim/deqs_checker.sv
sim/testbench.sv
